/* rtl/b64e_pkg.sv */
// Package with the shared types, constants and the character mapping of the base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] PadChar = 8'd61;

  typedef enum logic [1:0] {
    PhaseStart = 2'd0,
    PhaseOne   = 2'd1,
    PhaseTwo   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } sym_t;

  typedef struct packed {
    sym_t [3:0] syms;
    logic [1:0] last_idx;
    logic       fin;
  } job_t;

  function automatic logic [7:0] sym_to_char(sym_t s);
    logic [7:0] v;
    logic [7:0] ch;
    v = {2'b00, s.sextet};
    if (s.pad) begin
      ch = PadChar;
    end else begin
      case (s.sextet) inside
        [6'd0:6'd25]:  ch = 8'd65 + v;
        [6'd26:6'd51]: ch = 8'd97 + v - 8'd26;
        [6'd52:6'd61]: ch = 8'd48 + v - 8'd52;
        6'd62:         ch = 8'd43;
        default:       ch = 8'd47;
      endcase
    end
    return ch;
  endfunction

endpackage

/* rtl/b64e_front.sv */
// Front end: accepts message bytes, tracks the group phase and builds character jobs.
`timescale 1ns / 1ps

module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     message_byte_i,
  input  logic           is_final_byte_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output b64e_pkg::job_t q_job_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] pend_q, pend_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    if (accept) begin
      case (phase_q)
        PhaseOne: begin
          if (is_final_byte_i) begin
            phase_d = PhaseStart;
            pend_d  = 4'd0;
          end else begin
            phase_d = PhaseTwo;
            pend_d  = message_byte_i[3:0];
          end
        end
        PhaseTwo: begin
          phase_d = PhaseStart;
          pend_d  = 4'd0;
        end
        default: begin
          if (is_final_byte_i) begin
            phase_d = PhaseStart;
            pend_d  = 4'd0;
          end else begin
            phase_d = PhaseOne;
            pend_d  = {2'b00, message_byte_i[1:0]};
          end
        end
      endcase
    end
  end

  always_comb begin
    q_job_o          = '0;
    q_job_o.fin      = is_final_byte_i;
    case (phase_q)
      PhaseOne: begin
        q_job_o.syms[0].sextet = {pend_q[1:0], message_byte_i[7:4]};
        if (is_final_byte_i) begin
          q_job_o.syms[1].sextet = {message_byte_i[3:0], 2'b00};
          q_job_o.syms[2].pad    = 1'b1;
          q_job_o.last_idx       = 2'd2;
        end else begin
          q_job_o.last_idx       = 2'd0;
        end
      end
      PhaseTwo: begin
        q_job_o.syms[0].sextet = {pend_q, message_byte_i[7:6]};
        q_job_o.syms[1].sextet = message_byte_i[5:0];
        q_job_o.last_idx       = 2'd1;
      end
      default: begin
        q_job_o.syms[0].sextet = message_byte_i[7:2];
        if (is_final_byte_i) begin
          q_job_o.syms[1].sextet = {message_byte_i[1:0], 4'b0000};
          q_job_o.syms[2].pad    = 1'b1;
          q_job_o.syms[3].pad    = 1'b1;
          q_job_o.last_idx       = 2'd3;
        end else begin
          q_job_o.last_idx       = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseStart;
      pend_q  <= 4'd0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
// Short job queue between the front end and the character emitter.
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output b64e_pkg::job_t head_job_o
);
  import b64e_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/b64e_back.sv */
// Back end: walks the head job one character per cycle into the output register unless stalled.
`timescale 1ns / 1ps

module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  b64e_pkg::job_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     code_char_o,
  output logic           is_final_char_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       fin_q, fin_d;
  logic       load;
  logic       at_last;

  assign load    = !q_empty_i && (!valid_q || !out_stall_i);
  assign at_last = (idx_q == q_head_i.last_idx);
  assign q_pop_o = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    fin_d   = fin_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = sym_to_char(q_head_i.syms[idx_q]);
      fin_d   = at_last && q_head_i.fin;
      idx_d   = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    fin_q  <= fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign code_char_o     = char_q;
  assign is_final_char_o = fin_q;

endmodule

/* rtl/base64_stream_encoder_core.sv */
// Top level of the streaming base64 encoder with padding.
//
// Input channel: one message byte per transfer with a flag on the last byte.
// Output channel: one ASCII base64 character per transfer, '=' for padding,
// with a flag on the last character of the message.
// Both channels transfer when valid is high and stall is low.
// An accepted byte's job is written into the job queue, and its first
// character is then loaded from the queue head into the output register.
// The emitter sends one character per cycle while a job is queued and the
// output is not stalled; three bytes become four characters, a final byte up to four.
// The front end writes each byte's characters into a short job queue and
// stalls the input only when that queue is full.
// When the receiver stalls, the output register holds its character and
// the queue absorbs new bytes until it fills.
// Reset clears the group position, the queue and the output valid.
`timescale 1ns / 1ps

module base64_stream_encoder_core #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] message_byte_i,
  input  logic       is_final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] code_char_o,
  output logic       is_final_char_o
);
  import b64e_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  b64e_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_byte_i (message_byte_i),
    .is_final_byte_i(is_final_byte_i),
    .q_full_i       (full),
    .q_push_o       (push),
    .q_job_o        (push_job)
  );

  b64e_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_job_o(head_job)
  );

  b64e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (empty),
    .q_head_i       (head_job),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_char_o    (code_char_o),
    .is_final_char_o(is_final_char_o)
  );

endmodule

/* rtl/b64e_checker.sv */
// Port-level checker for the base64 encoder, bound to the top level.
`timescale 1ns / 1ps

module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] code_char_o,
  input logic       is_final_char_o
);

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_char_o)
      && $stable(is_final_char_o))
    else $error("Stalled output transfer changed.");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_char_o >= 8'd65 && code_char_o <= 8'd90)
      || (code_char_o >= 8'd97 && code_char_o <= 8'd122)
      || (code_char_o >= 8'd48 && code_char_o <= 8'd57)
      || code_char_o == 8'd43 || code_char_o == 8'd47 || code_char_o == 8'd61)
    else $error("Output character is outside the base64 alphabet.");

  a_pad_then_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && code_char_o == 8'd61 && !is_final_char_o
      |=> !out_valid_o || code_char_o == 8'd61)
    else $error("Padding was followed by a data character.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("Output valid during reset.");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .code_char_o    (code_char_o),
  .is_final_char_o(is_final_char_o)
);
